### hdl/shad_pkg.sv
// Package for the half-step stepper driver: command codes, register indexes,
// widths, reset values, shared structs and the coil pattern table.
// No dependencies.
package shad_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ANGLE = 2'd1,
    OP_CONT  = 2'd2,
    OP_DIR   = 2'd3
  } op_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CPR_W      = 11;
  localparam int unsigned IVL_W      = 10;
  localparam int unsigned NUM_W      = 10;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned SCALED_W   = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONT_INTERVAL  = 2'd1;

  localparam logic [CPR_W-1:0]    CPR_RESET   = 11'd512;
  localparam logic [IVL_W-1:0]    CI_RESET    = 10'd5;
  localparam logic [IVL_W-1:0]    IVL_RESET   = 10'd30;
  localparam logic [2:0]          PHASE_LAST  = 3'd7;
  localparam logic [CNT_W-1:0]    CNT_MAX     = 12'hFFF;
  localparam logic [SCALED_W-1:0] DEG_PER_REV = 21'd360;
  // Largest target count (4095) times 360; products above it saturate here.
  localparam logic [SCALED_W-1:0] SCALED_MAX  = 21'd1474200;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef struct packed {
    op_e              op;
    logic [NUM_W-1:0] angle;
    logic [NUM_W-1:0] interval;
  } cmd_t;

  typedef struct packed {
    logic [CPR_W-1:0] cycles_per_rev;
    logic [IVL_W-1:0] cont_interval;
  } cfg_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       running;
    logic       run_finished;
  } res_t;

  // Coil bits: bit 0 is A, bit 1 B, bit 2 C, bit 3 D.
  function automatic logic [3:0] coil_pattern(logic rev, logic [2:0] ph);
    logic [3:0] fwd;
    case (rev ? (3'd7 - ph) : ph)
      3'd0:    fwd = 4'h1;
      3'd1:    fwd = 4'h3;
      3'd2:    fwd = 4'h2;
      3'd3:    fwd = 4'h6;
      3'd4:    fwd = 4'h4;
      3'd5:    fwd = 4'hC;
      3'd6:    fwd = 4'h8;
      3'd7:    fwd = 4'h9;
      default: fwd = 4'h0;
    endcase
    return fwd;
  endfunction

endpackage

### hdl/shad_if.sv
// Valid/ready channel interfaces of the stepper driver: command items,
// result items and configuration writes. Depends on shad_pkg.
interface shad_item_if;
  import shad_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] angle_hundreds;
  logic [7:0] angle_tens;
  logic [7:0] angle_ones;
  logic [7:0] interval_hundreds;
  logic [7:0] interval_tens;
  logic [7:0] interval_ones;

  modport source (output valid, opcode, angle_hundreds, angle_tens, angle_ones,
                  interval_hundreds, interval_tens, interval_ones, input ready);
  modport sink (input valid, opcode, angle_hundreds, angle_tens, angle_ones,
                interval_hundreds, interval_tens, interval_ones, output ready);
endinterface

interface shad_result_if;
  logic valid;
  logic ready;
  logic coil_a;
  logic coil_b;
  logic coil_c;
  logic coil_d;
  logic running;
  logic run_finished;

  modport source (output valid, coil_a, coil_b, coil_c, coil_d, running, run_finished,
                  input ready);
  modport sink (input valid, coil_a, coil_b, coil_c, coil_d, running, run_finished,
                output ready);
endinterface

interface shad_cfg_if;
  import shad_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/shad_parse.sv
// Three-character ASCII decimal parser that stops at the first non-digit.
// Depends on shad_pkg.
module shad_parse (
  input  logic [7:0]                 char0_i,
  input  logic [7:0]                 char1_i,
  input  logic [7:0]                 char2_i,
  output logic [shad_pkg::NUM_W-1:0] value_o
);
  import shad_pkg::*;

  logic             ok0, ok1, ok2;
  logic [NUM_W-1:0] d0, d1, d2;

  assign ok0 = (char0_i >= ASCII_ZERO) && (char0_i <= ASCII_NINE);
  assign ok1 = ok0 && (char1_i >= ASCII_ZERO) && (char1_i <= ASCII_NINE);
  assign ok2 = ok1 && (char2_i >= ASCII_ZERO) && (char2_i <= ASCII_NINE);

  // For a digit character the low nibble is the digit value.
  assign d0 = NUM_W'(char0_i[3:0]);
  assign d1 = NUM_W'(char1_i[3:0]);
  assign d2 = NUM_W'(char2_i[3:0]);

  always_comb begin
    if (ok2) begin
      value_o = d0 * NUM_W'(100) + d1 * NUM_W'(10) + d2;
    end else if (ok1) begin
      value_o = d0 * NUM_W'(10) + d1;
    end else if (ok0) begin
      value_o = d0;
    end else begin
      value_o = '0;
    end
  end

endmodule

### hdl/shad_cfg_regs.sv
// Configuration registers of the stepper driver: cycles per revolution and
// continuous-mode step interval. Depends on shad_pkg and shad_cfg_if.
module shad_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  shad_cfg_if.sink        cfg_i,
  output shad_pkg::cfg_t  cfg_o
);
  import shad_pkg::*;

  logic [CPR_W-1:0] cpr_q;
  logic [IVL_W-1:0] ci_q;
  logic             wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RESET;
      ci_q  <= CI_RESET;
    end else if (wr) begin
      case (cfg_i.index)
        CFG_CYCLES_PER_REV: cpr_q <= cfg_i.data[CPR_W-1:0];
        CFG_CONT_INTERVAL:  ci_q  <= cfg_i.data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.cycles_per_rev = cpr_q;
  assign cfg_o.cont_interval  = ci_q;

endmodule

### hdl/shad_motor.sv
// Motor state and step logic: interval timer, phase sequencer, cycle count
// and target check. Depends on shad_pkg.
module shad_motor (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  shad_pkg::cmd_t  cmd_i,
  input  shad_pkg::cfg_t  cfg_i,
  output shad_pkg::res_t  res_o
);
  import shad_pkg::*;

  logic [2:0]          phase_q, phase_d;
  logic                rev_q, rev_d;
  logic                active_q, active_d;
  logic                endless_q, endless_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  // Scaled count: always cnt_q * 360, so the target check needs no divider.
  logic [SCALED_W-1:0] cs_q, cs_d;
  // Target kept as cycles_per_rev * angle, saturated at 4095 * 360.
  logic [SCALED_W-1:0] tgt_q, tgt_d;
  logic [IVL_W-1:0]    ivl_q, ivl_d;
  logic [IVL_W-1:0]    ms_q, ms_d;
  logic [3:0]          coil_q, coil_d;

  logic [IVL_W-1:0]    ms_inc;
  logic [SCALED_W-1:0] product;
  logic [SCALED_W-1:0] cs_step;
  logic [SCALED_W-1:0] tgt_diff;
  logic [CNT_W-1:0]    cnt_step;
  logic                hit;
  logic                finished;

  assign ms_inc  = ms_q + IVL_W'(1);
  assign product = SCALED_W'(cfg_i.cycles_per_rev) * SCALED_W'(cmd_i.angle);

  always_comb begin
    phase_d   = phase_q;
    rev_d     = rev_q;
    active_d  = active_q;
    endless_d = endless_q;
    cnt_d     = cnt_q;
    cs_d      = cs_q;
    tgt_d     = tgt_q;
    ivl_d     = ivl_q;
    ms_d      = ms_q;
    coil_d    = coil_q;
    finished  = 1'b0;
    cnt_step  = cnt_q;
    cs_step   = cs_q;
    tgt_diff  = '0;
    hit       = 1'b0;

    case (cmd_i.op)
      OP_TICK: begin
        if (active_q) begin
          if (ms_inc >= ivl_q) begin
            ms_d    = '0;
            coil_d  = coil_pattern(rev_q, phase_q);
            phase_d = phase_q + 3'd1;
            if (phase_q == PHASE_LAST) begin
              cnt_step = cnt_q + CNT_W'(1);
              cs_step  = (cnt_q == CNT_MAX) ? '0 : cs_q + DEG_PER_REV;
            end
            // Count equals floor(target/360) when 0 <= target - scaled < 360.
            tgt_diff = tgt_q - cs_step;
            hit      = (tgt_q >= cs_step) && (tgt_diff < DEG_PER_REV);
            if (!endless_q && hit) begin
              active_d = 1'b0;
              cnt_d    = '0;
              cs_d     = '0;
              finished = 1'b1;
            end else begin
              cnt_d = cnt_step;
              cs_d  = cs_step;
            end
          end else begin
            ms_d = ms_inc;
          end
        end
      end
      OP_ANGLE: begin
        tgt_d     = (product > SCALED_MAX) ? SCALED_MAX : product;
        ivl_d     = (cmd_i.interval == '0) ? IVL_W'(1) : cmd_i.interval;
        endless_d = 1'b0;
        active_d  = 1'b1;
        cnt_d     = '0;
        cs_d      = '0;
        ms_d      = '0;
      end
      OP_CONT: begin
        ivl_d     = (cfg_i.cont_interval == '0) ? IVL_W'(1) : cfg_i.cont_interval;
        endless_d = 1'b1;
        active_d  = 1'b1;
        cnt_d     = '0;
        cs_d      = '0;
        ms_d      = '0;
      end
      OP_DIR: begin
        rev_d = !rev_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      rev_q     <= 1'b1;
      active_q  <= 1'b0;
      endless_q <= 1'b0;
      cnt_q     <= '0;
      cs_q      <= '0;
      tgt_q     <= '0;
      ivl_q     <= IVL_RESET;
      ms_q      <= '0;
      coil_q    <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      rev_q     <= rev_d;
      active_q  <= active_d;
      endless_q <= endless_d;
      cnt_q     <= cnt_d;
      cs_q      <= cs_d;
      tgt_q     <= tgt_d;
      ivl_q     <= ivl_d;
      ms_q      <= ms_d;
      coil_q    <= coil_d;
    end
  end

  assign res_o.coils        = coil_d;
  assign res_o.running      = active_d;
  assign res_o.run_finished = finished;

  a_scaled_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q == SCALED_W'(cnt_q) * DEG_PER_REV)
    else $error("scaled count out of step with cycle count");

  a_timer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ivl_q != '0) && (ms_q < ivl_q))
    else $error("millisecond timer reached the step interval");

  a_target_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_q <= SCALED_MAX)
    else $error("stored target exceeds saturation limit");

endmodule

### hdl/stepper_half_step_angle_driver_core.sv
// Top level of the four-coil half-step stepper driver: input register,
// digit parsers, motor state logic and result register.
// Depends on shad_pkg, shad_if, shad_parse, shad_cfg_regs and shad_motor.

// The block takes one command transaction per clock cycle while the result
// side keeps up; back-pressure on results can stall it. An accepted command
// sits in an input register until it is applied, is decoded and applied to
// the motor state in a single pass, and its result is registered. The path
// between the two registers is set by the angle product (an 11 by 10 bit
// multiply) and the target compare. The command side stays ready while a
// result waits, until both the input and the result register are full.
module stepper_half_step_angle_driver_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  shad_item_if.sink      item_i,
  shad_result_if.source  result_o,
  shad_cfg_if.sink       cfg_i
);
  import shad_pkg::*;

  logic       in_valid_q;
  logic [1:0] opcode_q;
  logic [7:0] ang_h_q, ang_t_q, ang_o_q;
  logic [7:0] ivl_h_q, ivl_t_q, ivl_o_q;
  logic       out_valid_q;
  res_t       res_q;

  logic       accept;
  logic       advance;
  cmd_t       cmd;
  cfg_t       cfg;
  res_t       res;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= item_i.opcode;
      ang_h_q  <= item_i.angle_hundreds;
      ang_t_q  <= item_i.angle_tens;
      ang_o_q  <= item_i.angle_ones;
      ivl_h_q  <= item_i.interval_hundreds;
      ivl_t_q  <= item_i.interval_tens;
      ivl_o_q  <= item_i.interval_ones;
    end
  end

  assign cmd.op = op_e'(opcode_q);

  shad_parse u_parse_angle (
    .char0_i (ang_h_q),
    .char1_i (ang_t_q),
    .char2_i (ang_o_q),
    .value_o (cmd.angle)
  );

  shad_parse u_parse_interval (
    .char0_i (ivl_h_q),
    .char1_i (ivl_t_q),
    .char2_i (ivl_o_q),
    .value_o (cmd.interval)
  );

  shad_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  shad_motor u_motor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.coil_a       = res_q.coils[0];
  assign result_o.coil_b       = res_q.coils[1];
  assign result_o.coil_c       = res_q.coils[2];
  assign result_o.coil_d       = res_q.coils[3];
  assign result_o.running      = res_q.running;
  assign result_o.run_finished = res_q.run_finished;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending command left the input register without being applied");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("applied command produced no result");

  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.run_finished |-> !res_q.running)
    else $error("finished run still reported as running");

endmodule
